FILE: hw/rtl/sequence_gap_loss_tracker_defines.svh
// assertion macros for the sequence gap loss tracker
// used by sglt_ctrl and sglt_dpath; expects clk_i and rst_ni in scope
`ifndef SEQUENCE_GAP_LOSS_TRACKER_DEFINES_SVH
`define SEQUENCE_GAP_LOSS_TRACKER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define SGLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define SGLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sglt_pkg.sv
// shared types and constants of the sequence gap loss tracker
// no dependencies
`default_nettype none

package sglt_pkg;

  // register indexes of the config port
  localparam logic [0:0] CFG_JUMP_LIMIT   = 1'b0;
  localparam logic [0:0] CFG_MIN_EXPECTED = 1'b1;

  localparam logic [7:0]  JUMP_LIMIT_RESET   = 8'd64;
  localparam logic [15:0] MIN_EXPECTED_RESET = 16'd32;

  localparam logic [9:0]  PERMILLE_FULL = 10'd1000;

  // quotient never exceeds 1000, so 11 quotient bits cover it
  localparam int unsigned DIV_STEPS = 11;
  localparam int unsigned DIV_CNT_W = 4;

  typedef struct packed {
    logic load_in;
    logic update;
    logic sum;
    logic prep;
    logic div_step;
    logic load_out;
  } sglt_cmd_t;

  typedef struct packed {
    logic div_last;
  } sglt_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sglt_dpath.sv
// datapath: last sequence memory, seen flags, counters, config and divider
// depends on sglt_pkg and sequence_gap_loss_tracker_defines.svh
`default_nettype none

`include "sequence_gap_loss_tracker_defines.svh"

module sglt_dpath #(
  parameter int unsigned NUM_SOURCES = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i,
  input  wire logic [15:0]          in_data_i,
  input  wire sglt_pkg::sglt_cmd_t  cmd_i,
  output sglt_pkg::sglt_sts_t       sts_o,
  output logic [111:0]              out_data_o
);
  import sglt_pkg::*;

  localparam int unsigned IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic [7:0]             jump_limit_q;
  logic [15:0]            min_exp_q;
  logic [7:0]             src_q, seq_q, rd_q;
  logic [7:0]             mem_q [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] seen_q;
  logic [31:0]            lost_q, frames_q, exp_q;
  logic [41:0]            prod_q;
  logic                   low_rate_q;
  logic [32:0]            rem_q;
  logic [10:0]            nlo_q, quo_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic [31:0]            out_lost_q, out_frames_q, out_exp_q;
  logic [9:0]             out_perm_q;

  logic [IDX_W-1:0] idx_in, idx_q;
  logic             in_range, seen_hit, mem_we, count_loss;
  logic [7:0]       diff;
  logic [32:0]      sum33;
  logic [31:0]      exp_d;
  logic [42:0]      num;
  logic [32:0]      trial;
  logic             ge;
  logic [9:0]       perm;

  assign idx_in   = in_data_i[IDX_W-1:0];
  assign idx_q    = src_q[IDX_W-1:0];
  assign in_range = ({1'b0, src_q} < 9'(NUM_SOURCES));
  assign seen_hit = seen_q[idx_q];
  assign diff     = seq_q - rd_q;
  assign mem_we   = cmd_i.update && in_range && (!seen_hit || (diff != 8'd0));
  assign count_loss = cmd_i.update && in_range && seen_hit && (diff != 8'd0)
                      && (diff <= jump_limit_q);

  assign sum33 = {1'b0, frames_q} + {1'b0, lost_q};
  assign exp_d = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
  assign num   = {1'b0, prod_q} + {12'd0, exp_q[31:1]};
  assign trial = {rem_q[31:0], nlo_q[10]};
  assign ge    = (trial >= {1'b0, exp_q});
  assign perm  = low_rate_q ? 10'd0 :
                 ((quo_q > {1'b0, PERMILLE_FULL}) ? PERMILLE_FULL : quo_q[9:0]);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_limit_q <= JUMP_LIMIT_RESET;
      min_exp_q    <= MIN_EXPECTED_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_JUMP_LIMIT:   jump_limit_q <= cfg_data_i[7:0];
        CFG_MIN_EXPECTED: min_exp_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // last sequence memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      rd_q <= mem_q[idx_in];
    end
    if (mem_we) begin
      mem_q[idx_q] <= seq_q;
    end
  end

  // control state: seen flags and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= '0;
      lost_q   <= '0;
      frames_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.update) begin
        frames_q <= frames_q + 32'd1;
        if (in_range) begin
          seen_q[idx_q] <= 1'b1;
        end
      end
      if (count_loss) begin
        lost_q <= lost_q + {24'd0, diff - 8'd1};
      end
      if (cmd_i.prep) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      src_q <= in_data_i[7:0];
      seq_q <= in_data_i[15:8];
    end
    if (cmd_i.sum) begin
      exp_q      <= exp_d;
      prod_q     <= {10'd0, lost_q} * {32'd0, PERMILLE_FULL};
      low_rate_q <= (exp_d == 32'd0) || (exp_d < {16'd0, min_exp_q});
    end
    // numerator is below expected * 2^11, so the top bits start below the divisor
    if (cmd_i.prep) begin
      rem_q <= {1'b0, num[42:11]};
      nlo_q <= num[10:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? (trial - {1'b0, exp_q}) : trial;
      nlo_q <= {nlo_q[9:0], 1'b0};
      quo_q <= {quo_q[9:0], ge};
    end
    if (cmd_i.load_out) begin
      out_lost_q   <= lost_q;
      out_frames_q <= frames_q;
      out_exp_q    <= exp_q;
      out_perm_q   <= perm;
    end
  end

  assign sts_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign out_data_o = {6'd0, out_perm_q, out_exp_q, out_frames_q, out_lost_q};

  `SGLT_ASSERT_NOW(a_perm_cap, cmd_i.load_out, perm <= PERMILLE_FULL, "loss rate above cap")
  `SGLT_ASSERT_NOW(a_rem_below, cmd_i.div_step, (rem_q < {1'b0, exp_q}) || low_rate_q,
                   "divider remainder not below divisor")

endmodule

`default_nettype wire

FILE: hw/rtl/sglt_ctrl.sv
// controller state machine: sequences accept, update, divide and output load
// depends on sglt_pkg and sequence_gap_loss_tracker_defines.svh
`default_nettype none

`include "sequence_gap_loss_tracker_defines.svh"

module sglt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire sglt_pkg::sglt_sts_t sts_i,
  output sglt_pkg::sglt_cmd_t      cmd_o
);
  import sglt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_SUM  = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `SGLT_ASSERT_NEXT(a_accept_update, in_valid_i && in_ready_o, cmd_o.update,
                    "accepted item not updated next cycle")
  `SGLT_ASSERT_NOW(a_load_free, cmd_o.load_out, !out_valid_q || out_ready_i,
                   "result overwritten before taken")
  `SGLT_ASSERT_NEXT(a_div_out, cmd_o.div_step && sts_i.div_last, state_q == S_OUT,
                    "divider end not followed by output")

endmodule

`default_nettype wire

FILE: hw/rtl/sequence_gap_loss_tracker.sv
// a result shows on m_axis after update, sum, prep, 11 divider steps and output
// load, which waits for a free output register; a new item is taken only after
// that load; the loss rate uses a one-quotient-bit-per-cycle restoring divider
// reset: seen flags and counters clear at once, config returns to jump limit 64
// and minimum expected 32; last sequence memory is not cleared
`default_nettype none

module sequence_gap_loss_tracker #(
  parameter int unsigned NUM_SOURCES = 256  // tracked sources, 2 to 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // config write port, index 0 jump limit, index 1 minimum expected count
  input  wire logic          cfg_we_i,
  input  wire logic [0:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i,
  // input items
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [15:0]   s_axis_tdata,  // source_id[7:0], seq_number[15:8]
  // result items
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [111:0]       m_axis_tdata   // lost_total[31:0], frames_total[63:32],
                                            // expected_total[95:64],
                                            // loss_permille[105:96], zero pad
);

  sglt_pkg::sglt_cmd_t cmd;
  sglt_pkg::sglt_sts_t sts;

  // controller: one item at a time, output register frees the input side
  sglt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: per-source memory, counters, permille divider
  sglt_dpath #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire
